// ===== src/signed_int_to_decimal_ascii_unit_defines.svh =====
// Assertion macros used by the character emitter of the decimal text unit.
// Each macro checks a property on the rising edge of clk and is
// disabled while rst is high.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIDAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sidau_pkg.sv =====
`default_nettype none

package sidau_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int BITS_PER_STEP       = 4;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } conv_state_t;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SIGN,
    EMIT_DIGIT
  } emit_state_t;

  // Control for one transfer of a converted or classified item.
  typedef struct packed {
    logic valid;
    logic neg;
  } item_ctl_t;

  // Upper bound on the decimal digits of a magnitude up to 2**(width-1).
  function automatic int digit_slots(input int width);
    return (3 * width + 9) / 10;
  endfunction

  // Double dabble correction of one BCD digit before a shift.
  function automatic logic [3:0] dabble_adjust(input logic [3:0] d);
    return (d >= 4'd5) ? (d + 4'd3) : d;
  endfunction

endpackage

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii_unit.sv =====
`default_nettype none

// Signed integer to decimal ASCII text.
// Input channel: drive value and raise start; the item is transferred at a
// rising edge where start is high and busy is low. A two-entry queue sits
// behind the input; from empty, three numbers are taken before busy rises,
// one going straight on to the converter and two waiting in the queue.
// Result channel: one character per cycle on text_char, marked by strobe,
// with is_last high on the final character of a number. A negative number
// starts with '-'; digits follow most significant first, no leading zeros.
// There is no stall on the result side: every strobed cycle is a transfer.
// A number passes from the queue to the double dabble converter, which
// takes 4 magnitude bits a cycle and holds its result until the character
// emitter is idle; the emitter loads it and then sends its characters from
// a register, with strobe low after each last character. The converter can
// take the next number while the emitter still sends an earlier one.
// Reset (rst, synchronous) empties the queue and drops any number in work;
// strobe is low after reset.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = sidau_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  output logic                               busy,
  output logic                               strobe,
  output logic        [7:0]                  text_char,
  output logic                               is_last
);
  import sidau_pkg::*;

  // Digit slots cover the largest magnitude, 2**(VALUE_WIDTH-1).
  localparam int DIGITS = digit_slots(VALUE_WIDTH);
  localparam int IDXW   = $clog2(DIGITS);

  item_ctl_t              front_ctl;
  logic [VALUE_WIDTH-1:0] front_mag;
  logic                   conv_ready;
  item_ctl_t              conv_ctl;
  logic [DIGITS*4-1:0]    conv_bcd;
  logic [IDXW-1:0]        conv_top;
  logic                   emit_ready;

  // Front end: sign and magnitude, then the queue.
  sidau_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .out_ctl   (front_ctl),
    .out_mag   (front_mag),
    .out_ready (conv_ready)
  );

  // Binary to BCD conversion; holds its result until the emitter is free.
  sidau_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS),
    .IDXW        (IDXW)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (front_ctl),
    .in_mag    (front_mag),
    .in_ready  (conv_ready),
    .out_ctl   (conv_ctl),
    .out_bcd   (conv_bcd),
    .out_top   (conv_top),
    .out_ready (emit_ready)
  );

  // Character emitter: sign, then digits from the leading one down.
  sidau_emit #(
    .DIGITS (DIGITS),
    .IDXW   (IDXW)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (conv_ctl),
    .in_bcd    (conv_bcd),
    .in_top    (conv_top),
    .in_ready  (emit_ready),
    .strobe    (strobe),
    .text_char (text_char),
    .is_last   (is_last)
  );

endmodule

`default_nettype wire

// ===== src/sidau_front.sv =====
`default_nettype none

module sidau_front #(
  parameter int VALUE_WIDTH = sidau_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  output logic                               busy,
  output sidau_pkg::item_ctl_t               out_ctl,
  output logic        [VALUE_WIDTH-1:0]      out_mag,
  input  wire logic                          out_ready
);
  import sidau_pkg::*;

  localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_WIDTH-1:0] mag_q [QUEUE_DEPTH];
  logic                   neg_q [QUEUE_DEPTH];
  logic [PTRW-1:0]        wr_ptr;
  logic [PTRW-1:0]        rd_ptr;
  logic [CNTW-1:0]        count;

  logic                   push;
  logic                   pop;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] value_u;
  logic [VALUE_WIDTH-1:0] in_mag;

  // Sign and magnitude; the most negative value maps to 2**(width-1).
  assign value_u = value;
  assign in_neg  = value_u[VALUE_WIDTH-1];
  assign in_mag  = in_neg ? (~value_u + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_u;

  assign busy = (count == CNTW'(QUEUE_DEPTH));
  assign push = start && !busy;
  assign pop  = out_ready && (count != '0);

  assign out_ctl.valid = (count != '0);
  assign out_ctl.neg   = neg_q[rd_ptr];
  assign out_mag       = mag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mag_q[wr_ptr] <= in_mag;
      neg_q[wr_ptr] <= in_neg;
    end
  end

endmodule

`default_nettype wire

// ===== src/sidau_conv.sv =====
`default_nettype none

module sidau_conv #(
  parameter int VALUE_WIDTH = sidau_pkg::DEFAULT_VALUE_WIDTH,
  parameter int DIGITS      = sidau_pkg::digit_slots(sidau_pkg::DEFAULT_VALUE_WIDTH),
  parameter int IDXW        = $clog2(DIGITS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sidau_pkg::item_ctl_t       in_ctl,
  input  wire logic [VALUE_WIDTH-1:0]     in_mag,
  output logic                            in_ready,
  output sidau_pkg::item_ctl_t            out_ctl,
  output logic      [DIGITS*4-1:0]        out_bcd,
  output logic      [IDXW-1:0]            out_top,
  input  wire logic                       out_ready
);
  import sidau_pkg::*;

  localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PADW  = STEPS * BITS_PER_STEP;
  localparam int BCDW  = DIGITS * 4;
  localparam int STW   = $clog2(STEPS + 1);

  conv_state_t     state;
  conv_state_t     state_next;
  logic [PADW-1:0] mag_sr;
  logic [BCDW-1:0] bcd;
  logic [STW-1:0]  steps_left;
  logic            neg_r;

  logic [PADW-1:0] mag_step;
  logic [BCDW-1:0] bcd_step;
  logic [IDXW-1:0] top_c;

  // Several magnitude bits per cycle of shift-and-add-3.
  always_comb begin
    bcd_step = bcd;
    mag_step = mag_sr;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        bcd_step[d*4 +: 4] = dabble_adjust(bcd_step[d*4 +: 4]);
      end
      bcd_step = {bcd_step[BCDW-2:0], mag_step[PADW-1]};
      mag_step = {mag_step[PADW-2:0], 1'b0};
    end
  end

  // Position of the leading nonzero digit; digit zero when all are zero.
  always_comb begin
    top_c = '0;
    for (int d = 1; d < DIGITS; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        top_c = IDXW'(d);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CONV_IDLE: begin
        if (in_ctl.valid) begin
          state_next = CONV_RUN;
        end
      end
      CONV_RUN: begin
        if (steps_left == STW'(1)) begin
          state_next = CONV_DONE;
        end
      end
      CONV_DONE: begin
        if (out_ready) begin
          state_next = CONV_IDLE;
        end
      end
      default: state_next = CONV_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == CONV_IDLE);
    out_ctl.valid = (state == CONV_DONE);
    out_ctl.neg   = neg_r;
    out_bcd       = bcd;
    out_top       = top_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == CONV_IDLE) && in_ctl.valid) begin
      mag_sr     <= PADW'(in_mag);
      bcd        <= '0;
      steps_left <= STW'(STEPS);
      neg_r      <= in_ctl.neg;
    end else if (state == CONV_RUN) begin
      mag_sr     <= mag_step;
      bcd        <= bcd_step;
      steps_left <= steps_left - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/sidau_emit.sv =====
`default_nettype none

`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sidau_emit #(
  parameter int DIGITS = sidau_pkg::digit_slots(sidau_pkg::DEFAULT_VALUE_WIDTH),
  parameter int IDXW   = $clog2(DIGITS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sidau_pkg::item_ctl_t  in_ctl,
  input  wire logic [DIGITS*4-1:0]   in_bcd,
  input  wire logic [IDXW-1:0]       in_top,
  output logic                       in_ready,
  output logic                       strobe,
  output logic      [7:0]            text_char,
  output logic                       is_last
);
  import sidau_pkg::*;

  localparam int BCDW = DIGITS * 4;

  emit_state_t     state;
  emit_state_t     state_next;
  logic [BCDW-1:0] bcd_r;
  logic [IDXW-1:0] idx;

  logic            strobe_next;
  logic [7:0]      char_next;
  logic            last_next;
  logic [3:0]      digit;

  assign digit = bcd_r[idx*4 +: 4];

  always_comb begin
    state_next = state;
    unique case (state)
      EMIT_IDLE: begin
        if (in_ctl.valid) begin
          state_next = in_ctl.neg ? EMIT_SIGN : EMIT_DIGIT;
        end
      end
      EMIT_SIGN: state_next = EMIT_DIGIT;
      EMIT_DIGIT: begin
        if (idx == '0) begin
          state_next = EMIT_IDLE;
        end
      end
      default: state_next = EMIT_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == EMIT_IDLE);
    strobe_next = (state != EMIT_IDLE);
    char_next   = (state == EMIT_SIGN) ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, digit});
    last_next   = (state == EMIT_DIGIT) && (idx == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= EMIT_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    text_char <= char_next;
    is_last   <= last_next;
    if ((state == EMIT_IDLE) && in_ctl.valid) begin
      bcd_r <= in_bcd;
      idx   <= in_top;
    end else if ((state == EMIT_DIGIT) && (idx != '0)) begin
      idx <= idx - 1'b1;
    end
  end

  `SIDAU_ASSERT_SAME(a_char_legal, strobe, (text_char == CHAR_MINUS) || ((text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE)), "character outside the sign and digit set")
  `SIDAU_ASSERT_SAME(a_sign_not_last, strobe && (text_char == CHAR_MINUS), !is_last, "minus sign marked as last")
  `SIDAU_ASSERT_NEXT(a_run_continues, strobe && !is_last, strobe, "character run broke before its last character")
  `SIDAU_ASSERT_NEXT(a_gap_after_last, strobe && is_last, !strobe, "no idle cycle after the last character")

endmodule

`default_nettype wire

// ===== sim/decimal_text_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the decimal text unit, works out the characters
// that every accepted number must produce, and compares each strobed
// character with the oldest one still owed.
module decimal_text_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic                          strobe,
  input  wire logic        [7:0]             text_char,
  input  wire logic                          is_last,
  output int                                 mismatch_count,
  output int                                 chars_outstanding
);
  import sidau_pkg::*;

  localparam int MAX_DIGITS = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t owed_text[$];

  // Appends the decimal text of one number to the characters still owed.
  function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] number);
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [7:0]             digit_chars[MAX_DIGITS];
    logic                   negative;
    int                     n_digits;
    text_char_t             entry;
    negative  = number[VALUE_WIDTH-1];
    // The most negative value maps onto itself, which read as unsigned is
    // exactly its magnitude.
    magnitude = negative ? (~number + 1'b1) : number;
    n_digits  = 0;
    do begin
      digit_chars[n_digits] = CHAR_ZERO + 8'(magnitude % 10);
      magnitude = magnitude / 10;
      n_digits++;
    end while (magnitude != 0 && n_digits < MAX_DIGITS);
    if (negative) begin
      entry.ch   = CHAR_MINUS;
      entry.last = 1'b0;
      owed_text.push_back(entry);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      entry.ch   = digit_chars[i];
      entry.last = (i == 0);
      owed_text.push_back(entry);
    end
  endfunction

  // Both counts are two-state and start at zero; only this block drives them.
  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      owed_text.delete();
    end else begin
      if (strobe) begin
        if (owed_text.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected character transfer: expected none, actual %h last %b",
                   $realtime, text_char, is_last);
        end else begin
          want = owed_text.pop_front();
          if (text_char !== want.ch) begin
            mismatch_count++;
            $display("%0t: text_char mismatch: expected %h, actual %h",
                     $realtime, want.ch, text_char);
          end
          if (is_last !== want.last) begin
            mismatch_count++;
            $display("%0t: is_last mismatch: expected %b, actual %b",
                     $realtime, want.last, is_last);
          end
        end
      end
      if (start && !busy) begin
        queue_decimal_text(value);
      end
    end
    chars_outstanding = owed_text.size();
  end

endmodule

// ===== sim/signed_int_to_decimal_ascii_unit_test.sv =====
`timescale 1ns / 100ps

// Top of the testbench for the decimal text unit. This module only makes
// stimulus and gives the verdict; the checker beside the block predicts and
// compares every character.
module signed_int_to_decimal_ascii_unit_test;
  import sidau_pkg::*;

  localparam int VALUE_WIDTH    = DEFAULT_VALUE_WIDTH;
  localparam int RANDOM_NUMBERS = 300;
  // Cycles with no transfer on either side before the run is called hung.
  // The longest correct quiet stretch is the longest sender gap that pick_gap
  // gives plus the unit's first-character latency, so this leaves ample margin.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to keep watching after the last owed character, enough to catch
  // any stray character of a further number.
  localparam int TAIL_CYCLES    = 40;

  localparam logic signed [VALUE_WIDTH-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_WIDTH-1:0] MOST_NEGATIVE = 32'sh8000_0000;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          busy;
  logic                          strobe;
  logic        [7:0]             text_char;
  logic                          is_last;

  int mismatch_count;
  int chars_outstanding;
  int idle_cycles;

  signed_int_to_decimal_ascii_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .value(value),
    .busy(busy),
    .strobe(strobe),
    .text_char(text_char),
    .is_last(is_last)
  );

  decimal_text_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) text_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .strobe(strobe),
    .text_char(text_char),
    .is_last(is_last),
    .mismatch_count(mismatch_count),
    .chars_outstanding(chars_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog restarts on every transfer in either direction. If nothing
  // moves for too long, the unit has hung and the run ends as a failure.
  // The count is two-state, starts at zero and is held there during reset.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("signed_int_to_decimal_ascii_unit_test failed");
      $finish;
    end
  end

  // Presents one number at a falling edge and holds it until the unit takes
  // it. Busy is sampled at the rising edge, before the unit updates it, so
  // the test sees exactly what the unit saw. After the transfer, start stays
  // high if no gap follows, so numbers can go in back to back.
  task automatic send_number(input logic signed [VALUE_WIDTH-1:0] number,
                             input int gap_cycles);
    @(negedge clk);
    start <= 1'b1;
    value <= number;
    do @(posedge clk); while (busy);
    if (gap_cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      value <= $urandom;
      repeat (gap_cycles - 1) @(negedge clk);
    end
  endtask

  // Drops start and waits until every owed character has come out, so that
  // the next number meets a completely empty unit.
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (chars_outstanding != 0) @(negedge clk);
  endtask

  // Gap lengths: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Random numbers spread over every digit count, with a share of raw
  // 32-bit patterns so that every input bit toggles, and a share of values
  // near zero and near both ends of the range.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_number();
    int      roll;
    int      n_digits;
    longint  low_bound;
    longint  high_bound;
    longint  magnitude;
    roll = $urandom_range(9);
    if (roll < 3) return $urandom;
    if (roll == 8) return $signed(VALUE_WIDTH'($urandom_range(40))) - 20;
    if (roll == 9) begin
      case ($urandom_range(4))
        0: return MOST_POSITIVE;
        1: return MOST_NEGATIVE;
        2: return MOST_NEGATIVE + 1;
        3: return MOST_POSITIVE - 1;
        default: return '0;
      endcase
    end
    // Pick how many digits the magnitude has, then a magnitude of that size.
    n_digits  = $urandom_range(10, 1);
    low_bound = 1;
    repeat (n_digits - 1) low_bound = low_bound * 10;
    high_bound = low_bound * 10 - 1;
    if (n_digits == 1) low_bound = 0;
    if (high_bound > 64'sd2147483647) high_bound = 64'sd2147483647;
    magnitude = $urandom_range(32'(high_bound), 32'(low_bound));
    return $urandom_range(1) ? -VALUE_WIDTH'(magnitude) : VALUE_WIDTH'(magnitude);
  endfunction

  logic signed [VALUE_WIDTH-1:0] directed_numbers[$];

  initial begin
    int gap;
    rst   = 1'b1;
    start = 1'b0;
    value = '0;

    // Extremes of the range, zero, the lowest two and the highest digit-count
    // boundaries, the most negative value with its exact magnitude path, and
    // alternating bit patterns.
    directed_numbers = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
      32'sd999999999, -32'sd999999999, 32'sd1000000000, -32'sd1000000000,
      32'sd1234567890, -32'sd1234567890, MOST_POSITIVE, MOST_NEGATIVE,
      MOST_NEGATIVE + 1, 32'sh5555_5555, 32'shAAAA_AAAA, -32'sd7
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed numbers go in first, mostly back to back, so the input queue fills
    // and busy has to hold the sender off.
    foreach (directed_numbers[i]) begin
      send_number(directed_numbers[i], (i % 4 == 3) ? 2 : 0);
    end

    // Let the unit empty out completely before the random part starts.
    wait_for_drain();

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      // Every third block of 25 numbers runs with no gaps at all; the
      // others use random gaps so that pauses land on every phase of a
      // conversion and of a character run.
      gap = ((i / 25) % 3 == 1) ? 0 : pick_gap();
      send_number(pick_number(), gap);
      if (i % 97 == 96) begin
        wait_for_drain();
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Wait for every owed character, then watch a little longer for strays.
    while (chars_outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("signed_int_to_decimal_ascii_unit_test passed");
    end else begin
      $display("signed_int_to_decimal_ascii_unit_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/sidau_pkg.sv
src/sidau_front.sv
src/sidau_conv.sv
src/sidau_emit.sv
src/signed_int_to_decimal_ascii_unit.sv
sim/decimal_text_checker.sv
sim/signed_int_to_decimal_ascii_unit_test.sv
